@@ design/pfpa_pkg.sv @@
// shared types, constants and the ring mean function of the particulate frame parser
package pfpa_pkg;

  // frame layout
  localparam logic [7:0] FRAME_HEADER = 8'd170;
  localparam int         FRAME_LENGTH = 10;
  localparam int         POS_W        = $clog2(FRAME_LENGTH);
  localparam logic [POS_W-1:0] POS_FIRST_PM  = POS_W'(2);
  localparam logic [POS_W-1:0] POS_PM25_HI   = POS_W'(3);
  localparam logic [POS_W-1:0] POS_PM10_LO   = POS_W'(4);
  localparam logic [POS_W-1:0] POS_PM10_HI   = POS_W'(5);
  localparam logic [POS_W-1:0] POS_LAST_DATA = POS_W'(7);
  localparam logic [POS_W-1:0] POS_CHECK     = POS_W'(8);
  localparam logic [POS_W-1:0] POS_LAST      = POS_W'(FRAME_LENGTH - 1);

  // ring of readings
  localparam int RING_DEPTH = 8;
  localparam int RING_IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int SUM_W      = 16 + RING_IDX_W;

  // mean by reciprocal multiply, exact for any sum below 2**SUM_W
  localparam int              DIV_L  = $clog2(RING_DEPTH);
  localparam int              DIV_S  = SUM_W + DIV_L;
  localparam int              DIV_MW = SUM_W + 1;
  localparam int              PROD_W = SUM_W + DIV_MW;
  localparam longint unsigned DIV_M  = (64'd1 << DIV_S) / RING_DEPTH + 1;

  // frame status codes
  localparam logic STATUS_GOOD    = 1'b0;
  localparam logic STATUS_BAD_SUM = 1'b1;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_IDX_W = 1;
  localparam int QUEUE_CNT_W = 2;

  // one parsed frame handed from front to back
  typedef struct packed {
    logic        good;
    logic [15:0] pm25;
    logic [15:0] pm10;
  } frame_t;

  // floor(sum / RING_DEPTH)
  function automatic logic [15:0] ring_mean(logic [SUM_W-1:0] sum);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(sum) * PROD_W'(DIV_M);
    return 16'(prod >> DIV_S);
  endfunction

endpackage

@@ design/pfpa_if.sv @@
// channel interfaces: received byte words and result words

interface pfpa_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface pfpa_res_if;
  logic        valid;
  logic        ready;
  logic        frame_status;
  logic [15:0] pm25_tenths;
  logic [15:0] pm10_tenths;
  logic [15:0] pm25_average;
  logic [15:0] pm10_average;

  modport source (output valid, output frame_status, output pm25_tenths,
                  output pm10_tenths, output pm25_average, output pm10_average,
                  input ready);
  modport sink   (input valid, input frame_status, input pm25_tenths,
                  input pm10_tenths, input pm25_average, input pm10_average,
                  output ready);
endinterface

@@ design/pfpa_front.sv @@
// front end: frame sync, byte collection and checksum
module pfpa_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_byte,
  input  logic                 q_full,
  output logic                 q_push,
  output pfpa_pkg::frame_t     q_data
);

  logic [pfpa_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]                 chk_r, chk_nxt;
  logic                       good_r, good_nxt;
  logic [15:0]                pm25_r, pm25_nxt;
  logic [15:0]                pm10_r, pm10_nxt;
  logic                       accept;

  // stall only when the closing word finds the queue full
  assign in_ready = (pos_r != pfpa_pkg::POS_LAST) || !q_full;
  assign accept   = in_valid && in_ready;

  // position and field capture
  always_comb begin
    pos_nxt  = pos_r;
    chk_nxt  = chk_r;
    good_nxt = good_r;
    pm25_nxt = pm25_r;
    pm10_nxt = pm10_r;
    if (accept) begin
      priority if (pos_r == '0) begin
        if (in_byte == pfpa_pkg::FRAME_HEADER) pos_nxt = pfpa_pkg::POS_W'(1);
      end else if (pos_r == pfpa_pkg::POS_LAST) begin
        pos_nxt = '0;
      end else begin
        pos_nxt = pos_r + pfpa_pkg::POS_W'(1);
      end

      // running checksum over the data bytes
      if (pos_r == pfpa_pkg::POS_FIRST_PM) begin
        chk_nxt = in_byte;
      end else if (pos_r > pfpa_pkg::POS_FIRST_PM && pos_r <= pfpa_pkg::POS_LAST_DATA) begin
        chk_nxt = chk_r + in_byte;
      end

      if (pos_r == pfpa_pkg::POS_CHECK)    good_nxt       = (chk_r == in_byte);
      if (pos_r == pfpa_pkg::POS_FIRST_PM) pm25_nxt[7:0]  = in_byte;
      if (pos_r == pfpa_pkg::POS_PM25_HI)  pm25_nxt[15:8] = in_byte;
      if (pos_r == pfpa_pkg::POS_PM10_LO)  pm10_nxt[7:0]  = in_byte;
      if (pos_r == pfpa_pkg::POS_PM10_HI)  pm10_nxt[15:8] = in_byte;
    end
  end

  // hand the finished frame to the queue
  assign q_push       = accept && (pos_r == pfpa_pkg::POS_LAST);
  assign q_data.good  = good_r;
  assign q_data.pm25  = pm25_r;
  assign q_data.pm10  = pm10_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_r  <= chk_nxt;
    good_r <= good_nxt;
    pm25_r <= pm25_nxt;
    pm10_r <= pm10_nxt;
  end

endmodule

@@ design/pfpa_queue.sv @@
// two-entry queue of parsed frames between front and back
module pfpa_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  pfpa_pkg::frame_t push_data,
  input  logic             pop,
  output pfpa_pkg::frame_t pop_data,
  output logic             full,
  output logic             not_empty
);

  pfpa_pkg::frame_t                 slot_r [pfpa_pkg::QUEUE_DEPTH];
  logic [pfpa_pkg::QUEUE_IDX_W-1:0] wr_r, rd_r;
  logic [pfpa_pkg::QUEUE_CNT_W-1:0] cnt_r;

  assign full      = (cnt_r == pfpa_pkg::QUEUE_CNT_W'(pfpa_pkg::QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign pop_data  = slot_r[rd_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + pfpa_pkg::QUEUE_IDX_W'(1);
      if (pop)  rd_r <= rd_r + pfpa_pkg::QUEUE_IDX_W'(1);
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + pfpa_pkg::QUEUE_CNT_W'(1);
        2'b01:   cnt_r <= cnt_r - pfpa_pkg::QUEUE_CNT_W'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) slot_r[wr_r] <= push_data;
  end

endmodule

@@ design/pfpa_back.sv @@
// back end: ring update, running sums and result register
module pfpa_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_not_empty,
  input  pfpa_pkg::frame_t q_data,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_status,
  output logic [15:0]      out_pm25,
  output logic [15:0]      out_pm10,
  output logic [15:0]      out_avg25,
  output logic [15:0]      out_avg10
);

  logic [15:0]                     ring25_r [pfpa_pkg::RING_DEPTH];
  logic [15:0]                     ring10_r [pfpa_pkg::RING_DEPTH];
  logic [pfpa_pkg::RING_IDX_W-1:0] ptr_r, ptr_nxt;
  logic [pfpa_pkg::SUM_W-1:0]      sum25_r, sum25_nxt;
  logic [pfpa_pkg::SUM_W-1:0]      sum10_r, sum10_nxt;
  logic                            valid_r;
  logic                            status_r;
  logic [15:0]                     pm25_r, pm10_r;
  logic                            update;

  // take a frame whenever the result register is free or being drained
  assign q_pop  = q_not_empty && (!valid_r || out_ready);
  assign update = q_pop && q_data.good;

  // running sums swap the oldest entry for the new reading
  always_comb begin
    sum25_nxt = sum25_r - pfpa_pkg::SUM_W'(ring25_r[ptr_r]) + pfpa_pkg::SUM_W'(q_data.pm25);
    sum10_nxt = sum10_r - pfpa_pkg::SUM_W'(ring10_r[ptr_r]) + pfpa_pkg::SUM_W'(q_data.pm10);
    ptr_nxt   = (ptr_r == pfpa_pkg::RING_IDX_W'(pfpa_pkg::RING_DEPTH - 1)) ?
                '0 : ptr_r + pfpa_pkg::RING_IDX_W'(1);
  end

  // ring state, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < pfpa_pkg::RING_DEPTH; i++) begin
        ring25_r[i] <= '0;
        ring10_r[i] <= '0;
      end
      ptr_r   <= '0;
      sum25_r <= '0;
      sum10_r <= '0;
    end else if (update) begin
      ring25_r[ptr_r] <= q_data.pm25;
      ring10_r[ptr_r] <= q_data.pm10;
      ptr_r           <= ptr_nxt;
      sum25_r         <= sum25_nxt;
      sum10_r         <= sum10_nxt;
    end
  end

  // result word valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (q_pop) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  // result payload, readings zeroed on a bad checksum
  always_ff @(posedge clk) begin
    if (q_pop) begin
      status_r <= q_data.good ? pfpa_pkg::STATUS_GOOD : pfpa_pkg::STATUS_BAD_SUM;
      pm25_r   <= q_data.good ? q_data.pm25 : 16'd0;
      pm10_r   <= q_data.good ? q_data.pm10 : 16'd0;
    end
  end

  // sums change only together with the result register, so the means track it
  assign out_valid  = valid_r;
  assign out_status = status_r;
  assign out_pm25   = pm25_r;
  assign out_pm10   = pm10_r;
  assign out_avg25  = pfpa_pkg::ring_mean(sum25_r);
  assign out_avg10  = pfpa_pkg::ring_mean(sum10_r);

endmodule

@@ design/particulate_frame_parser_avg.sv @@
// Particulate sensor frame parser: takes one received serial byte per word, syncs on the
// 170 header, collects 10-byte frames and checks the wrapping sum of bytes 2..7 against
// byte 8. Each finished frame gives one result word: PM2.5 and PM10 in tenths with the
// truncated means of 8-entry rings (cleared at reset), or a checksum error with zero
// readings and unchanged means. One byte is accepted every cycle; in_ch.ready drops only
// on the tenth byte of a frame while the two-frame queue to the back end is full, which
// takes a stalled result port. The tenth byte puts the frame into the queue, from which
// the back end loads the result register. There is no clearing pass after reset.
module particulate_frame_parser_avg (
  input  logic       clk,
  input  logic       rst_n,
  pfpa_rx_if.sink    in_ch,
  pfpa_res_if.source out_ch
);

  pfpa_pkg::frame_t push_data;
  pfpa_pkg::frame_t pop_data;
  logic             push;
  logic             pop;
  logic             q_full;
  logic             q_not_empty;

  // frame sync and checksum
  pfpa_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_byte  (in_ch.rx_byte),
    .q_full   (q_full),
    .q_push   (push),
    .q_data   (push_data)
  );

  // decoupling queue
  pfpa_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  // ring averaging and result register
  pfpa_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_data      (pop_data),
    .q_pop       (pop),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_status  (out_ch.frame_status),
    .out_pm25    (out_ch.pm25_tenths),
    .out_pm10    (out_ch.pm10_tenths),
    .out_avg25   (out_ch.pm25_average),
    .out_avg10   (out_ch.pm10_average)
  );

endmodule

@@ design/pfpa_checker.sv @@
// port-level checks for the particulate frame parser, bound to the top level
module pfpa_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        frame_status,
  input logic [15:0] pm25_tenths,
  input logic [15:0] pm10_tenths,
  input logic [15:0] pm25_average,
  input logic [15:0] pm10_average
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(frame_status) &&
      $stable(pm25_tenths) && $stable(pm10_tenths) &&
      $stable(pm25_average) && $stable(pm10_average))
    else $error("result word changed while stalled");

  // checksum error words carry zero readings
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && frame_status == pfpa_pkg::STATUS_BAD_SUM |->
      pm25_tenths == 16'd0 && pm10_tenths == 16'd0)
    else $error("error word carries a reading");

  // reset leaves no result pending and the input open
  a_reset_clean: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("state left over after reset");

  // with the result port draining, the input never stalls
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready && $past(out_ready) && $past(out_ready, 2) && $past(rst_n, 2) |-> in_ready)
    else $error("input stalled while results drain");

endmodule

bind particulate_frame_parser_avg pfpa_checker u_pfpa_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .frame_status (out_ch.frame_status),
  .pm25_tenths  (out_ch.pm25_tenths),
  .pm10_tenths  (out_ch.pm10_tenths),
  .pm25_average (out_ch.pm25_average),
  .pm10_average (out_ch.pm10_average)
);

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// testbench of the particulate frame parser: byte stream stimulus, reading predictor, scoreboard

module tb;
  import pfpa_pkg::*;

  localparam int ITEMS          = 1750;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int IDLE_PCT       = 38;
  localparam int REPORT_MAX     = 10;
  localparam int DIR_ROWS       = 23;
  localparam int STEADY_FROM    = 700;
  localparam int STEADY_TO      = 1000;
  localparam int HOT_FRAME_LO   = 40;
  localparam int HOT_FRAME_HI   = 49;
  localparam int PAUSE_FRAME    = 90;
  localparam int TAIL_CYCLES    = 8;

  // one result word as the sink sees it
  typedef struct packed {
    logic        status;
    logic [15:0] pm25;
    logic [15:0] pm10;
    logic [15:0] avg25;
    logic [15:0] avg10;
  } reading_t;

  // one directed row: the byte and, where obvious, the reading it finishes
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       typed;
    reading_t   reading;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic steady;

  pfpa_rx_if  rx_ch ();
  pfpa_res_if res_ch ();

  particulate_frame_parser_avg u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (rx_ch),
    .out_ch (res_ch)
  );

  // predictor state
  int unsigned frame_fill;
  logic [7:0]  frame_buf [FRAME_LENGTH];
  logic [15:0] ring25 [RING_DEPTH];
  logic [15:0] ring10 [RING_DEPTH];
  int unsigned slot_ptr;
  int unsigned sum25;
  int unsigned sum10;

  reading_t pending_readings [$];
  int unsigned bytes_taken;
  int unsigned mismatches;
  int unsigned stuck_cycles;

  // noise, a max frame after reset, then a frame with a bad checksum
  stim_row_t frame_rows [DIR_ROWS] = '{
    '{8'h00, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'hAB, 1'b0, '0},
    '{FRAME_HEADER, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'hFC, 1'b0, '0},
    '{8'hFF, 1'b1, {STATUS_GOOD, 16'hFFFF, 16'hFFFF, 16'd8191, 16'd8191}},
    '{FRAME_HEADER, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b1, {STATUS_BAD_SUM, 16'd0, 16'd0, 16'd8191, 16'd8191}}
  };

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // advance the frame parser by one byte
  function automatic void parse_byte(input logic [7:0] b, output logic kept,
                                     output logic produced, output reading_t r);
    logic [7:0]  chk;
    logic [15:0] v25;
    logic [15:0] v10;
    kept     = 1'b0;
    produced = 1'b0;
    r        = '0;
    if (frame_fill == 0 && b != FRAME_HEADER) return;
    kept = 1'b1;
    frame_buf[frame_fill] = b;
    frame_fill++;
    if (frame_fill < FRAME_LENGTH) return;
    frame_fill = 0;
    produced = 1'b1;
    chk = '0;
    for (int i = POS_FIRST_PM; i <= POS_LAST_DATA; i++) chk = chk + frame_buf[i];
    if (chk != frame_buf[POS_CHECK]) begin
      r.status = STATUS_BAD_SUM;
      r.avg25  = 16'(sum25 / RING_DEPTH);
      r.avg10  = 16'(sum10 / RING_DEPTH);
      return;
    end
    v25 = {frame_buf[POS_PM25_HI], frame_buf[POS_FIRST_PM]};
    v10 = {frame_buf[POS_PM10_HI], frame_buf[POS_PM10_LO]};
    sum25 = sum25 - ring25[slot_ptr] + v25;
    sum10 = sum10 - ring10[slot_ptr] + v10;
    ring25[slot_ptr] = v25;
    ring10[slot_ptr] = v10;
    slot_ptr = (slot_ptr + 1) % RING_DEPTH;
    r.status = STATUS_GOOD;
    r.pm25   = v25;
    r.pm10   = v10;
    r.avg25  = 16'(sum25 / RING_DEPTH);
    r.avg10  = 16'(sum10 / RING_DEPTH);
  endfunction

  // drive one byte word, starting and ending at a falling edge
  task automatic put_byte(input logic [7:0] b, input logic typed, input reading_t typed_exp);
    reading_t r;
    logic     kept;
    logic     produced;
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      rx_ch.valid   = 1'b0;
      rx_ch.rx_byte = 8'($urandom);
      @(negedge clk);
    end
    rx_ch.valid   = 1'b1;
    rx_ch.rx_byte = b;
    do @(posedge clk); while (!rx_ch.ready);
    parse_byte(b, kept, produced, r);
    if (kept) bytes_taken++;
    if (produced) pending_readings.push_back(typed ? typed_exp : r);
    @(negedge clk);
  endtask

  // hold the sender off until every reading has come back
  task automatic drain_readings();
    rx_ch.valid = 1'b0;
    while (pending_readings.size() != 0) @(negedge clk);
  endtask

  // reading value with the extremes favored
  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 16'd0;
      1, 2:    return 16'hFFFF;
      3:       return 16'($urandom_range(0, 255));
      default: return 16'($urandom);
    endcase
  endfunction

  // frame with random command, id and tail bytes; bad gives it a wrong checksum
  task automatic send_frame(input logic [15:0] v25, input logic [15:0] v10, input logic bad);
    logic [7:0] body [FRAME_LENGTH];
    logic [7:0] chk;
    body[0]             = FRAME_HEADER;
    body[1]             = 8'($urandom);
    body[POS_FIRST_PM]  = v25[7:0];
    body[POS_PM25_HI]   = v25[15:8];
    body[POS_PM10_LO]   = v10[7:0];
    body[POS_PM10_HI]   = v10[15:8];
    body[6]             = 8'($urandom);
    body[POS_LAST_DATA] = 8'($urandom);
    chk = '0;
    for (int i = POS_FIRST_PM; i <= POS_LAST_DATA; i++) chk = chk + body[i];
    body[POS_CHECK] = bad ? chk + 8'($urandom_range(1, 255)) : chk;
    body[POS_LAST]  = 8'($urandom);
    for (int i = 0; i < FRAME_LENGTH; i++) put_byte(body[i], 1'b0, '0);
  endtask

  // result sink stalls
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      res_ch.ready = steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // scoreboard and watchdog
  always @(posedge clk) begin
    reading_t want;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (pending_readings.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected result word: status %0d pm25 %0d pm10 %0d avg %0d/%0d",
                   res_ch.frame_status, res_ch.pm25_tenths, res_ch.pm10_tenths,
                   res_ch.pm25_average, res_ch.pm10_average);
      end else begin
        want = pending_readings.pop_front();
        if (res_ch.frame_status !== want.status || res_ch.pm25_tenths !== want.pm25 ||
            res_ch.pm10_tenths !== want.pm10 || res_ch.pm25_average !== want.avg25 ||
            res_ch.pm10_average !== want.avg10) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("mismatch: exp status %0d pm25 %0d pm10 %0d avg %0d/%0d, got %0d %0d %0d %0d/%0d",
                     want.status, want.pm25, want.pm10, want.avg25, want.avg10,
                     res_ch.frame_status, res_ch.pm25_tenths, res_ch.pm10_tenths,
                     res_ch.pm25_average, res_ch.pm10_average);
        end
      end
    end
    if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready) || !rst_n)
      stuck_cycles = 0;
    else
      stuck_cycles++;
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // stimulus
  initial begin
    int unsigned frames;
    int unsigned kind;
    int unsigned run_len;
    logic [15:0] v25;
    logic [15:0] v10;

    rst_n         = 1'b0;
    steady        = 1'b0;
    rx_ch.valid   = 1'b0;
    rx_ch.rx_byte = 8'h00;
    frame_fill    = 0;
    slot_ptr      = 0;
    sum25         = 0;
    sum10         = 0;
    bytes_taken   = 0;
    mismatches    = 0;
    stuck_cycles  = 0;
    frames        = 0;
    for (int i = 0; i < RING_DEPTH; i++) begin
      ring25[i] = '0;
      ring10[i] = '0;
    end

    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // directed table
    for (int i = 0; i < DIR_ROWS; i++)
      put_byte(frame_rows[i].rx_byte, frame_rows[i].typed, frame_rows[i].reading);
    drain_readings();

    // random frames, broken frames and line noise
    while (bytes_taken < ITEMS) begin
      steady = (bytes_taken >= STEADY_FROM && bytes_taken < STEADY_TO);
      if (frames == PAUSE_FRAME) drain_readings();
      kind = $urandom_range(0, 99);
      if (kind < 78) begin
        // a run of max readings, meant to fill the rings to the top
        if (frames >= HOT_FRAME_LO && frames <= HOT_FRAME_HI) begin
          v25 = 16'hFFFF;
          v10 = 16'hFFFF;
        end else begin
          v25 = pick_value();
          v10 = pick_value();
        end
        send_frame(v25, v10, 1'b0);
      end else if (kind < 88) begin
        send_frame(pick_value(), pick_value(), 1'b1);
      end else if (kind < 94) begin
        // header followed by a cut-off frame body
        put_byte(FRAME_HEADER, 1'b0, '0);
        run_len = $urandom_range(1, 8);
        repeat (run_len) put_byte(8'($urandom), 1'b0, '0);
      end else begin
        run_len = $urandom_range(1, 6);
        repeat (run_len) put_byte(8'($urandom), 1'b0, '0);
      end
      frames++;
    end

    steady = 1'b0;
    drain_readings();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
